### hdl/spq_pkg.sv
package spq_pkg;

  // Queue size and derived widths.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LIST   = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_REMOVED  = 3'd1;
  localparam logic [2:0] STAT_LISTED   = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  // Operations broadcast to every cell of the chain.
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  // One stored entry.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // Command shared by all cells in a cycle.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } cell_cmd_t;

endpackage

### hdl/spq_req_if.sv
interface spq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] item_value;
  logic signed [15:0] item_priority;

  modport source (output valid, output req_type, output item_value, output item_priority,
                  input ready);
  modport sink (input valid, input req_type, input item_value, input item_priority,
                output ready);
endinterface

### hdl/spq_rsp_if.sv
interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] out_value;
  logic signed [15:0] out_priority;
  logic               last;

  modport source (output valid, output status, output out_value, output out_priority,
                  output last, input ready);
  modport sink (input valid, input status, input out_value, input out_priority,
                input last, output ready);
endinterface

### hdl/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t    left_q,
  input  logic               left_gt,
  input  spq_pkg::entry_t    right_q,
  input  spq_pkg::entry_t    head_q,
  output spq_pkg::entry_t    q,
  output logic               gt
);
  import spq_pkg::*;

  entry_t q_next;

  // The cell is past the insertion point when it is empty or holds a larger priority number.
  assign gt = !q.valid || (q.prio > cmd.prio);

  // Next contents: keep its own, or take the left neighbor, the new entry, the right neighbor or the head.
  always_comb begin
    q_next = q;
    case (cmd.op)
      OP_INSERT: begin
        if (left_gt) begin
          q_next = left_q;
        end else if (gt) begin
          q_next.valid = 1'b1;
          q_next.value = cmd.value;
          q_next.prio  = cmd.prio;
        end
      end
      OP_SHIFT: begin
        q_next = right_q;
      end
      OP_ROTATE: begin
        if (right_q.valid) begin
          q_next = right_q;
        end else if (q.valid) begin
          q_next = head_q;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  // Only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    q.value <= q_next.value;
    q.prio  <= q_next.prio;
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
  end

endmodule

### hdl/sorted_priority_queue_core.sv
// Channel  Role    Payload                                  Transfer
// req      sink    req_type, item_value, item_priority      valid && ready
// rsp      source  status, out_value, out_priority, last    valid && ready
//
// Insert and remove update the whole chain of cells at once.
// A list request enters the list state and sends out one stored entry at a time from the head,
// rotating the chain so that it ends in its original order.
// Reset (rst, synchronous) empties the queue and the output register.
// A new request is taken only when no list is in progress and the output register
// is empty or being drained; a stalled rsp holds the chain still.
module sorted_priority_queue_core (
  input  logic clk,
  input  logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] list_idx;
  logic [IDX_W-1:0] list_idx_next;

  logic               out_valid;
  logic [2:0]         out_status;
  logic signed [31:0] out_value;
  logic signed [15:0] out_prio;
  logic               out_last;

  logic               load;
  logic [2:0]         load_status;
  logic signed [31:0] load_value;
  logic signed [15:0] load_prio;
  logic               load_last;

  cell_cmd_t cmd;
  entry_t    cells [DEPTH];
  logic      gts   [DEPTH];
  entry_t    empty_entry;

  logic out_free;
  logic accept;
  logic list_end;

  assign empty_entry = '0;
  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept = req.valid && req.ready;
  assign list_end = ({1'b0, list_idx} == (count - CNT_W'(1)));

  // Chain of cells, head at index zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_q;
    logic   left_gt;
    entry_t right_q;

    if (i == 0) begin : g_head
      assign left_q  = empty_entry;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_q  = cells[i-1];
      assign left_gt = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_q = empty_entry;
    end else begin : g_body
      assign right_q = cells[i+1];
    end

    spq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .left_q  (left_q),
      .left_gt (left_gt),
      .right_q (right_q),
      .head_q  (cells[0]),
      .q       (cells[i]),
      .gt      (gts[i])
    );
  end

  // Request decode and list sequencing.
  always_comb begin
    state_next    = state;
    count_next    = count;
    list_idx_next = list_idx;
    cmd.op        = OP_HOLD;
    cmd.value     = req.item_value;
    cmd.prio      = req.item_priority;
    load          = 1'b0;
    load_status   = STAT_EMPTY;
    load_value    = '0;
    load_prio     = '0;
    load_last     = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_INSERT: begin
              load       = 1'b1;
              load_value = req.item_value;
              load_prio  = req.item_priority;
              if (count == CNT_W'(DEPTH)) begin
                load_status = STAT_FULL;
              end else begin
                load_status = STAT_INSERTED;
                cmd.op      = OP_INSERT;
                count_next  = count + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              load = 1'b1;
              if (count != '0) begin
                load_status = STAT_REMOVED;
                load_value  = cells[0].value;
                load_prio   = cells[0].prio;
                cmd.op      = OP_SHIFT;
                count_next  = count - CNT_W'(1);
              end
            end
            REQ_LIST: begin
              if (count == '0) begin
                load = 1'b1;
              end else begin
                state_next    = ST_LIST;
                list_idx_next = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          load          = 1'b1;
          load_status   = STAT_LISTED;
          load_value    = cells[0].value;
          load_prio     = cells[0].prio;
          load_last     = list_end;
          cmd.op        = OP_ROTATE;
          list_idx_next = list_idx + IDX_W'(1);
          if (list_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      list_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_idx <= list_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= load_status;
      out_value  <= load_value;
      out_prio   <= load_prio;
      out_last   <= load_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_value    = out_value;
  assign rsp.out_priority = out_prio;
  assign rsp.last         = out_last;

endmodule
